// File: rtl/srb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg
// Types, constants and the tanh table of the stereo resonator bank.
// ----------------------------------------------------------------------------
package srb_pkg;

	localparam int MAX_VOICES  = 8;
	localparam int TANH_POINTS = 64;
	localparam int SLOTS       = 7;

	localparam int TP_BITS     = $clog2(TANH_POINTS);
	localparam int VOICE_W     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int COEF_DEPTH  = MAX_VOICES * SLOTS;
	localparam int COEF_AW     = $clog2(COEF_DEPTH);
	localparam int ST_DEPTH    = 2 * MAX_VOICES;
	localparam int ST_AW       = VOICE_W + 1;

	localparam logic [1:0] CFG_DRIVE = 2'd0;
	localparam logic [1:0] CFG_MIX   = 2'd1;
	localparam logic [1:0] CFG_GAIN  = 2'd2;

	localparam logic [2:0] SLOT_A2     = 3'd2;
	localparam logic [2:0] SLOT_EXCITE = 3'd3;
	localparam logic [2:0] SLOT_ALPHA  = 3'd4;
	localparam logic [2:0] SLOT_LEVEL  = 3'd5;

	typedef struct packed {
		logic               command;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic [5:0]         coef_index;
		logic signed [23:0] coef_value;
	} in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} out_t;

	typedef logic signed [23:0] tanh_tab_t [TANH_POINTS + 1];

	localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

	// Restoring long division, used only while the table is built.
	function automatic longint unsigned div_u64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic signed [23:0] tanh_entry(input int i);
		longint unsigned one;
		longint unsigned t;
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint unsigned en;
		longint unsigned e;
		longint          s;
		one  = 64'd1 << 30;
		t    = (longint'(i) << 34) / TANH_POINTS;
		n    = t >> 30;
		f    = t & (one - 64'd1);
		term = one;
		en   = one;
		s    = longint'(one);
		for (int k = 1; k <= 20; k++) begin
			term = div_u64((term * f) >> 30, 64'(k));
			if ((k % 2) == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		if (s < 0) s = 0;
		for (longint unsigned kk = 0; kk < n; kk++) begin
			en = ((en * EXP_M1_Q30) + (one >> 1)) >> 30;
		end
		e = ((longint'(s) * en) + (one >> 1)) >> 30;
		if (e > one) e = one;
		return 24'(div_u64(((one - e) << 20) + ((one + e) >> 1), one + e));
	endfunction

	function automatic tanh_tab_t build_tanh();
		tanh_tab_t tab;
		for (int i = 0; i <= TANH_POINTS; i++) begin
			tab[i] = tanh_entry(i);
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

// File: rtl/stereo_resonator_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_resonator_bank
// Resonator bank driven by a soft-clipped mono sum of the stereo input, with panned wet mix.
// ----------------------------------------------------------------------------
// A sample item is worked from acceptance to a valid result by one shared multiplier stepping
// through every resonator and by the single read port of each memory; the next item is taken
// only once the block has registered the result and returned to idle.
// A coefficient write item is taken in idle and gives no result.
// A result that is not taken holds the block in its last step until it is.
// Reset restores the register defaults and clears all state through valid bits.
module stereo_resonator_bank (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  srb_pkg::in_t      in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output srb_pkg::out_t     out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [14:0]       cfg_data
);
	import srb_pkg::*;

	typedef enum logic [24:0] {
		ST_IDLE = 25'h0000001,
		ST_E0   = 25'h0000002,
		ST_E1   = 25'h0000004,
		ST_XS   = 25'h0000008,
		ST_TB   = 25'h0000010,
		ST_TR   = 25'h0000020,
		ST_RC   = 25'h0000040,
		ST_SR   = 25'h0000080,
		ST_M1   = 25'h0000100,
		ST_M2   = 25'h0000200,
		ST_M3   = 25'h0000400,
		ST_YS   = 25'h0000800,
		ST_D1   = 25'h0001000,
		ST_D2   = 25'h0002000,
		ST_LV   = 25'h0004000,
		ST_F1   = 25'h0008000,
		ST_F2   = 25'h0010000,
		ST_F3   = 25'h0020000,
		ST_G0   = 25'h0040000,
		ST_G1   = 25'h0080000,
		ST_G3   = 25'h0100000,
		ST_G4   = 25'h0200000,
		ST_G5   = 25'h0400000,
		ST_G6   = 25'h0800000,
		ST_OUT  = 25'h1000000
	} state_t;

	function automatic logic signed [55:0] rnd_sh(input logic signed [55:0] x, input int n);
		return (x + (56'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [23:0] clamp24(input logic signed [55:0] x,
		input logic signed [55:0] lim);
		logic signed [55:0] r;
		r = x;
		if (x > lim) r = lim;
		else if (x < -lim) r = -lim;
		return r[23:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [55:0] x);
		logic signed [23:0] r;
		if (x > 56'sd8388607) r = 24'sh7FFFFF;
		else if (x < -56'sd8388608) r = 24'sh800000;
		else r = x[23:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [55:0] x);
		logic signed [15:0] r;
		if (x > 56'sd32767) r = 16'sh7FFF;
		else if (x < -56'sd32768) r = 16'sh8000;
		else r = x[15:0];
		return r;
	endfunction

	state_t state_q;

	logic [14:0] drive_q;
	logic [12:0] mix_q;
	logic [14:0] gain_q;

	logic [COEF_DEPTH-1:0] cvld_q;
	logic [ST_DEPTH-1:0]   svld_q;
	logic signed [23:0]    coef_mem [COEF_DEPTH];
	logic [71:0]           st_mem [ST_DEPTH];

	logic signed [23:0] cf_rd_q;
	logic [71:0]        st_rd_q;
	logic signed [23:0] cf_q [SLOTS];

	logic [VOICE_W-1:0] v_q;
	logic               c_q;
	logic [2:0]         k_q;
	logic               tex_q;
	logic               out_valid_q;
	logic signed [23:0] fb_q;

	logic signed [55:0] acc_q;
	logic signed [55:0] pr_q;
	logic signed [55:0] accl_q;
	logic signed [55:0] accr_q;
	logic signed [27:0] accfb_q;
	logic signed [15:0] li_q;
	logic signed [15:0] ri_q;
	logic signed [23:0] ex_q;
	logic signed [23:0] w_q;
	logic signed [23:0] y_q;
	logic signed [23:0] d_q;
	logic signed [23:0] tw_q;
	logic signed [22:0] s_q;
	logic [22:0]        ta_q;
	logic               neg_q;
	logic signed [15:0] ol_q;
	logic signed [15:0] or_q;
	out_t               out_q;

	logic signed [27:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [55:0] prod;
	logic [14:0]        drive_c;
	logic [12:0]        mix_c;
	logic signed [20:0] mono;
	logic signed [23:0] st_prev;
	logic signed [23:0] st_older;
	logic signed [23:0] st_damp;
	logic signed [23:0] xs;
	logic signed [24:0] xs_abs;
	logic [TP_BITS:0]   tk;
	logic signed [23:0] t_lo;
	logic signed [23:0] t_hi;
	logic [22:0]        t_f;
	logic signed [23:0] t_r;
	logic signed [23:0] dn;
	logic [COEF_AW-1:0] ca;
	logic [ST_AW-1:0]   sa;
	logic               in_acc;
	logic               last_v;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign drive_c = (drive_q < 15'd819) ? 15'd819 : ((drive_q > 15'd16384) ? 15'd16384 : drive_q);
	assign mix_c   = (mix_q > 13'd4096) ? 13'd4096 : mix_q;
	assign mono    = {(17'(li_q) + 17'(ri_q)), 4'b0000};

	assign st_prev  = st_rd_q[71:48];
	assign st_older = st_rd_q[47:24];
	assign st_damp  = st_rd_q[23:0];

	assign ca = COEF_AW'(v_q) * COEF_AW'(SLOTS) + COEF_AW'(k_q);
	assign sa = {v_q, c_q};
	assign last_v = (v_q == VOICE_W'(MAX_VOICES - 1));

	assign xs     = sat24(rnd_sh(acc_q, 20));
	assign xs_abs = xs[23] ? -25'(xs) : 25'(xs);
	assign tk     = {1'b0, ta_q[22 -: TP_BITS]};
	assign t_lo   = TANH_TAB[tk];
	assign t_hi   = TANH_TAB[tk + (TP_BITS+1)'(1)];
	assign t_f    = {ta_q[22-TP_BITS:0], TP_BITS'(0)};
	assign t_r    = neg_q ? -(w_q + 24'(rnd_sh(pr_q, 23)))
	                      : (w_q + 24'(rnd_sh(pr_q, 23)));
	assign dn     = sat24(56'(st_damp) + rnd_sh(pr_q, 20));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_E0: begin
				mul_a = 28'(fb_q);
				mul_b = 28'sd230687;
			end
			ST_E1: begin
				mul_a = 28'(mono);
				mul_b = 28'($signed({1'b0, drive_c}));
			end
			ST_TB: begin
				mul_a = 28'(t_hi) - 28'(t_lo);
				mul_b = 28'($signed({1'b0, t_f}));
			end
			ST_M1: begin
				mul_a = 28'(ex_q);
				mul_b = 28'(cf_q[SLOT_EXCITE]);
			end
			ST_M2: begin
				mul_a = 28'(cf_q[{2'b00, c_q}]);
				mul_b = 28'(st_prev);
			end
			ST_M3: begin
				mul_a = 28'(cf_q[SLOT_A2]);
				mul_b = 28'(st_older);
			end
			ST_D1: begin
				mul_a = 28'(y_q) - 28'(st_damp);
				mul_b = 28'(cf_q[SLOT_ALPHA]);
			end
			ST_LV: begin
				mul_a = 28'(d_q);
				mul_b = 28'(cf_q[SLOT_LEVEL + {2'b00, c_q}]);
			end
			ST_F1: begin
				mul_a = 28'(fb_q);
				mul_b = 28'sd964690;
			end
			ST_F2: begin
				mul_a = accfb_q;
				mul_b = 28'sd26214;
			end
			ST_G1: begin
				mul_a = 28'(tw_q);
				mul_b = 28'sd1468006;
			end
			ST_G3: begin
				mul_a = 28'(w_q);
				mul_b = 28'($signed({1'b0, mix_c}));
			end
			ST_G5: begin
				mul_a = 28'(s_q);
				mul_b = 28'($signed({1'b0, gain_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drive_q     <= 15'd4710;
			mix_q       <= 13'd2253;
			gain_q      <= 15'd4096;
			cvld_q      <= '0;
			svld_q      <= '0;
			v_q         <= '0;
			c_q         <= 1'b0;
			k_q         <= '0;
			tex_q       <= 1'b0;
			out_valid_q <= 1'b0;
			fb_q        <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_DRIVE: drive_q <= cfg_data;
					CFG_MIX:   mix_q   <= cfg_data[12:0];
					CFG_GAIN:  gain_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.command) begin
							if ({1'b0, in_data.coef_index} < 7'(COEF_DEPTH))
								cvld_q[COEF_AW'(in_data.coef_index)] <= 1'b1;
						end else begin
							state_q <= ST_E0;
						end
					end
				end
				ST_E0: state_q <= ST_E1;
				ST_E1: begin
					tex_q   <= 1'b1;
					state_q <= ST_XS;
				end
				ST_XS: state_q <= ST_TB;
				ST_TB: state_q <= ST_TR;
				ST_TR: begin
					if (tex_q) begin
						v_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RC;
					end else begin
						state_q <= ST_G3;
					end
				end
				ST_RC: begin
					if (k_q == 3'(SLOTS)) begin
						c_q     <= 1'b0;
						state_q <= ST_SR;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_SR: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_YS;
				ST_YS: state_q <= ST_D1;
				ST_D1: state_q <= ST_D2;
				ST_D2: begin
					svld_q[sa] <= 1'b1;
					state_q    <= ST_LV;
				end
				ST_LV: begin
					if (!c_q) begin
						c_q     <= 1'b1;
						state_q <= ST_SR;
					end else if (last_v) begin
						state_q <= ST_F1;
					end else begin
						v_q     <= v_q + VOICE_W'(1);
						k_q     <= '0;
						state_q <= ST_RC;
					end
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: begin
					fb_q    <= clamp24(rnd_sh(acc_q, 20), 56'sd1572864);
					c_q     <= 1'b0;
					state_q <= ST_G0;
				end
				ST_G0: state_q <= ST_G1;
				ST_G1: begin
					tex_q   <= 1'b0;
					state_q <= ST_XS;
				end
				ST_G3: state_q <= ST_G4;
				ST_G4: state_q <= ST_G5;
				ST_G5: state_q <= ST_G6;
				ST_G6: begin
					if (!c_q) begin
						c_q     <= 1'b1;
						state_q <= ST_G0;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.command && ({1'b0, in_data.coef_index} < 7'(COEF_DEPTH)))
			coef_mem[COEF_AW'(in_data.coef_index)] <= in_data.coef_value;
		if (state_q == ST_RC && k_q != 3'(SLOTS))
			cf_rd_q <= cvld_q[ca] ? coef_mem[ca] : '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_D2)
			st_mem[sa] <= {y_q, st_prev, dn};
		if (state_q == ST_SR)
			st_rd_q <= svld_q[sa] ? st_mem[sa] : '0;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				li_q    <= in_data.left_in;
				ri_q    <= in_data.right_in;
				accl_q  <= '0;
				accr_q  <= '0;
				accfb_q <= '0;
			end
			ST_E0: acc_q <= prod;
			ST_E1: acc_q <= acc_q + (prod <<< 8);
			ST_XS: begin
				neg_q <= xs[23];
				ta_q  <= (xs_abs > 25'sd8388607) ? 23'h7FFFFF : xs_abs[22:0];
			end
			ST_TB: begin
				pr_q <= prod;
				w_q  <= t_lo;
			end
			ST_TR: begin
				if (tex_q) ex_q <= t_r;
				else w_q <= t_r;
			end
			ST_RC: begin
				if (k_q != 3'd0) cf_q[k_q - 3'd1] <= cf_rd_q;
			end
			ST_M1: acc_q <= prod;
			ST_M2: acc_q <= acc_q + prod;
			ST_M3: acc_q <= acc_q + prod;
			ST_YS: y_q <= clamp24(rnd_sh(acc_q, 20), 56'sd6291456);
			ST_D1: pr_q <= prod;
			ST_D2: d_q <= dn;
			ST_LV: begin
				if (c_q) accr_q <= accr_q + prod;
				else accl_q <= accl_q + prod;
				accfb_q <= accfb_q + 28'(d_q);
			end
			ST_F1: acc_q <= prod;
			ST_F2: acc_q <= acc_q + prod;
			ST_G0: tw_q <= sat24(rnd_sh(c_q ? accr_q : accl_q, 20));
			ST_G1: acc_q <= prod;
			ST_G3: pr_q <= prod;
			ST_G4: s_q <= (23'(c_q ? ri_q : li_q) <<< 5) + 23'(rnd_sh(pr_q, 12));
			ST_G5: pr_q <= prod;
			ST_G6: begin
				if (c_q) or_q <= sat16(rnd_sh(pr_q, 17));
				else ol_q <= sat16(rnd_sh(pr_q, 17));
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.left_out  <= ol_q;
					out_q.right_out <= or_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: tb/stereo_resonator_bank_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_resonator_bank_test
// Drives sample and coefficient items with random gaps and back pressure,
// predicts every output pair from its own model of the resonator bank and
// compares each result field by field, under several register settings.
// ----------------------------------------------------------------------------
module stereo_resonator_bank_test;
	import srb_pkg::*;

	localparam longint Q20_MAX = 8388607;
	localparam longint Q20_MIN = -8388608;
	localparam longint K_FB_IN = 230687;
	localparam longint K_FB_KEEP = 964690;
	localparam longint K_FB_SUM = 26214;
	localparam longint K_WET = 1468006;
	localparam longint LIM6 = 6291456;
	localparam longint LIM15 = 1572864;
	localparam int ITEM_LATENCY = 5 + MAX_VOICES * 24 + 22;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [14:0] cfg_data = '0;

	stereo_resonator_bank u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	longint tanh_lut [TANH_POINTS + 1];
	longint coefs [COEF_DEPTH];
	longint prev_y [ST_DEPTH];
	longint old_y [ST_DEPTH];
	longint smooth_y [ST_DEPTH];
	longint fb_level;
	longint drive_reg = 4710;
	longint mix_reg = 2253;
	longint gain_reg = 4096;

	in_t pending_items [$];
	out_t expected_outputs [$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	task automatic add_item(input in_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint soft_clip(longint x);
		longint a, p, k, f, r;
		a = x < 0 ? -x : x;
		if (a > Q20_MAX) a = Q20_MAX;
		p = a * TANH_POINTS;
		k = p >>> 23;
		f = p & 64'h7FFFFF;
		r = tanh_lut[k] + round_shift((tanh_lut[k + 1] - tanh_lut[k]) * f, 23);
		return x < 0 ? -r : r;
	endfunction

	function automatic longint tanh_point(int i);
		longint unsigned one, t, n, f, term, en, e;
		longint s;
		one = 64'd1 << 30;
		t = (longint'(i) << 34) / TANH_POINTS;
		n = t >> 30;
		f = t & (one - 1);
		term = one;
		en = one;
		s = longint'(one);
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 30) / longint'(k);
			if (k % 2) s -= longint'(term);
			else s += longint'(term);
		end
		if (s < 0) s = 0;
		for (longint unsigned j = 0; j < n; j++) en = (en * 64'd395007542 + (one >> 1)) >> 30;
		e = (longint'(s) * en + (one >> 1)) >> 30;
		if (e > one) e = one;
		return longint'((((one - e) << 20) + ((one + e) >> 1)) / (one + e));
	endfunction

	task automatic resonate(input in_t it);
		longint li, ri, mono, drv, mix, ex, acc_l, acc_r, acc_fb;
		longint y, d, w_l, w_r, o_l, o_r;
		int s, b;
		out_t r;
		if (it.command) begin
			if (it.coef_index < COEF_DEPTH) coefs[it.coef_index] = it.coef_value;
			return;
		end
		li = it.left_in;
		ri = it.right_in;
		mono = (li + ri) * 16;
		drv = clip(drive_reg, 819, 16384);
		mix = clip(mix_reg, 0, 4096);
		ex = soft_clip(clip(round_shift(mono * drv * 256 + fb_level * K_FB_IN, 20),
			Q20_MIN, Q20_MAX));
		acc_l = 0;
		acc_r = 0;
		acc_fb = 0;
		for (int v = 0; v < MAX_VOICES; v++) begin
			b = v * SLOTS;
			for (int c = 0; c < 2; c++) begin
				s = v * 2 + c;
				y = round_shift(ex * coefs[b + 3] + coefs[b + c] * prev_y[s]
					+ coefs[b + 2] * old_y[s], 20);
				y = clip(y, -LIM6, LIM6);
				old_y[s] = prev_y[s];
				prev_y[s] = y;
				d = smooth_y[s];
				d = clip(d + round_shift((y - d) * coefs[b + 4], 20), Q20_MIN, Q20_MAX);
				smooth_y[s] = d;
				if (c == 0) acc_l += d * coefs[b + 5];
				else acc_r += d * coefs[b + 6];
				acc_fb += d;
			end
		end
		fb_level = clip(round_shift(fb_level * K_FB_KEEP + acc_fb * K_FB_SUM, 20),
			-LIM15, LIM15);
		w_l = soft_clip(clip(round_shift(clip(round_shift(acc_l, 20), Q20_MIN, Q20_MAX)
			* K_WET, 20), Q20_MIN, Q20_MAX));
		w_r = soft_clip(clip(round_shift(clip(round_shift(acc_r, 20), Q20_MIN, Q20_MAX)
			* K_WET, 20), Q20_MIN, Q20_MAX));
		o_l = round_shift((li * 32 + round_shift(w_l * mix, 12)) * gain_reg, 17);
		o_r = round_shift((ri * 32 + round_shift(w_r * mix, 12)) * gain_reg, 17);
		r.left_out = 16'(clip(o_l, -32768, 32767));
		r.right_out = 16'(clip(o_r, -32768, 32767));
		expected_outputs.insert(expected_outputs.size(), r);
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			resonate(in_data);
			void'(pending_items.pop_front());
		end
		if (!(in_valid && !in_ready)) begin
			if (pending_items.size() > 0 && ($urandom_range(0, 3) != 0)) begin
				in_valid <= 1'b1;
				in_data <= pending_items[0];
			end else begin
				in_valid <= 1'b0;
				if ($urandom_range(0, 40) == 0) repeat ($urandom_range(20, 300)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 9) < 7)
			|| ($urandom_range(0, 30) == 0 ? 1'b0 : 1'b0);
		if (out_valid && out_ready) begin
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				if (out_data.left_out !== expected_outputs[0].left_out) begin
					$display("%0t: left_out expected %0d actual %0d", $time,
						expected_outputs[0].left_out, out_data.left_out);
					errors++;
				end
				if (out_data.right_out !== expected_outputs[0].right_out) begin
					$display("%0t: right_out expected %0d actual %0d", $time,
						expected_outputs[0].right_out, out_data.right_out);
					errors++;
				end
				void'(expected_outputs.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("** stereo_resonator_bank: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_DRIVE) drive_reg = val;
		else if (idx == CFG_MIX) mix_reg = val & 15'h1FFF;
		else gain_reg = val;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (ITEM_LATENCY + 10) @(posedge clk);
	endtask

	function automatic in_t sample_item(int l, int r);
		in_t it;
		it = '0;
		it.left_in = 16'(l);
		it.right_in = 16'(r);
		it.coef_index = 6'($urandom);
		it.coef_value = 24'($urandom);
		return it;
	endfunction

	function automatic in_t coef_item(int idx, int val);
		in_t it;
		it = '0;
		it.command = 1'b1;
		it.coef_index = 6'(idx);
		it.coef_value = 24'(val);
		it.left_in = 16'($urandom);
		it.right_in = 16'($urandom);
		return it;
	endfunction

	function automatic int rand_coef(int slot);
		case (slot)
			0, 1: return $urandom_range(0, 3) == 0 ? int'($urandom) : 1900000 + $urandom_range(0, 190000);
			2: return $urandom_range(0, 3) == 0 ? int'($urandom) : -1000000 + $urandom_range(0, 40000);
			default: return $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 1048576);
		endcase
	endfunction

	task automatic random_phase(int n);
		int slot;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				slot = $urandom_range(0, 63);
				add_item(coef_item(slot,
					slot < COEF_DEPTH ? rand_coef(slot % SLOTS) : int'($urandom)));
			end else if ($urandom_range(0, 9) == 0) begin
				add_item(sample_item($urandom_range(0, 1) ? 32767 : -32768,
					$urandom_range(0, 1) ? 32767 : -32768));
			end else begin
				add_item(sample_item(int'(16'($urandom)), int'(16'($urandom))));
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		for (int i = 0; i <= TANH_POINTS; i++) tanh_lut[i] = tanh_point(i);
		foreach (coefs[i]) coefs[i] = 0;
		foreach (prev_y[i]) begin
			prev_y[i] = 0;
			old_y[i] = 0;
			smooth_y[i] = 0;
		end
		fb_level = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_item(sample_item(32767, 32767));
		add_item(sample_item(-32768, -32768));
		add_item(sample_item(0, 0));
		add_item(coef_item(0, 2000000));
		add_item(coef_item(1, 2050000));
		add_item(coef_item(2, -1020000));
		add_item(coef_item(3, 1048576));
		add_item(coef_item(4, 300000));
		add_item(coef_item(5, 1048576));
		add_item(coef_item(6, 1048576));
		add_item(coef_item(COEF_DEPTH - 1, 8388607));
		add_item(coef_item(COEF_DEPTH - 3, -8388608));
		add_item(coef_item(COEF_DEPTH, 123456));
		add_item(coef_item(63, -1));
		add_item(sample_item(32767, -32768));
		add_item(sample_item(-32768, 32767));
		add_item(sample_item(12345, -321));
		add_item(sample_item(32767, 32767));
		wait_drained();

		hold_off = 1'b1;
		for (int i = 0; i < 6; i++) add_item(sample_item(int'(16'($urandom)), 1000));
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
		random_phase(180);

		write_reg(CFG_DRIVE, 15'd0);
		write_reg(CFG_MIX, 15'd0);
		write_reg(CFG_GAIN, 15'd32767);
		random_phase(170);
		write_reg(CFG_DRIVE, 15'h7FFF);
		write_reg(CFG_MIX, 15'h7FFF);
		write_reg(CFG_GAIN, 15'd0);
		random_phase(170);
		write_reg(CFG_DRIVE, 15'd16384);
		write_reg(CFG_MIX, 15'd4096);
		write_reg(CFG_GAIN, 15'd32531);
		random_phase(170);
		write_reg(CFG_DRIVE, 15'd819);
		write_reg(CFG_MIX, 15'd4097);
		write_reg(CFG_GAIN, 15'd4096);
		random_phase(150);
		write_reg(CFG_DRIVE, 15'($urandom));
		write_reg(CFG_MIX, 15'($urandom_range(0, 4096)));
		write_reg(CFG_GAIN, 15'($urandom_range(0, 32531)));
		random_phase(150);

		if (errors == 0) begin
			$display("** stereo_resonator_bank: PASSED **");
		end else begin
			$display("** stereo_resonator_bank: FAILED **");
		end
		$finish;
	end
endmodule
